>>> rtl/kalman_position_velocity_filter_defines.svh
// ----------------------------------------------------------------------------
// kalman_position_velocity_filter_defines
// assertion macros shared by the filter rtl
// ----------------------------------------------------------------------------
`ifndef KALMAN_POSITION_VELOCITY_FILTER_DEFINES_SVH
`define KALMAN_POSITION_VELOCITY_FILTER_DEFINES_SVH

// implication checked on every clock edge outside reset
`define KPV_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define KPV_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/kpv_pkg.sv
// ----------------------------------------------------------------------------
// kpv_pkg
// shared types and constants of the position and velocity filter
// ----------------------------------------------------------------------------
package kpv_pkg;

  localparam int unsigned RegW  = 33;

  localparam logic [1:0] CmdInit    = 2'd0;
  localparam logic [1:0] CmdPredict = 2'd1;
  localparam logic [1:0] CmdUpdate  = 2'd2;

  localparam logic RegProcNoise = 1'b0;
  localparam logic RegMeasNoise = 1'b1;

  localparam logic [63:0] OneQ  = 64'h0000_0001_0000_0000;
  localparam logic [63:0] VMax  = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] SMin  = 64'h8000_0000_0000_0000;
  localparam logic [RegW-1:0] ProcNoiseReset = 33'd4294967;
  localparam logic [RegW-1:0] MeasNoiseReset = 33'd214748365;

  typedef struct packed {
    logic        start;
    logic        sgn;
    logic [63:0] a;
    logic [63:0] b;
  } kpv_mul_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] res;
  } kpv_mul_rsp_t;

  typedef struct packed {
    logic        start;
    logic [63:0] p;
    logic [63:0] s;
  } kpv_div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] q;
  } kpv_div_rsp_t;

  function automatic logic [63:0] sadd(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] r;
    r = a + b;
    if (a[63] == b[63] && r[63] != a[63]) return a[63] ? SMin : VMax;
    return r;
  endfunction

  function automatic logic [63:0] ssub(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] r;
    r = a - b;
    if (a[63] != b[63] && r[63] != a[63]) return a[63] ? SMin : VMax;
    return r;
  endfunction

  function automatic logic [63:0] vadd(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] r;
    r = {1'b0, a} + {1'b0, b};
    if (r[64] || r[63]) return VMax;
    return r[63:0];
  endfunction

endpackage

>>> rtl/kalman_position_velocity_filter.sv
// ----------------------------------------------------------------------------
// kalman_position_velocity_filter
// two-axis diagonal kalman filter in q32.32, one shared multiplier and divider
// ----------------------------------------------------------------------------
// channel  dir  payload
// in_      in   tdata: pos_lat, pos_lon, acc_lat, acc_lon, time_step; tuser: command
// out_     out  tdata: est_lat, est_lon, est_vel_lat, est_vel_lon, out_var_lat, out_var_lon
// cfg_     in   register index and 33-bit value
// init goes straight to the result; predict runs nine multiplies (dt2 once, then
// four per axis) and update runs per axis one division and two multiplies, on
// the 96-step divider and the 4-step multiplier.
// in_tready is high only while the sequencer is idle and no result waits.
// synchronous active-low reset loads the origin state and register defaults.
module kalman_position_velocity_filter (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [319:0] in_tdata,  // pos_lat, pos_lon, acc_lat, acc_lon, time_step, pad
  input  logic [1:0]   in_tuser,  // command
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [383:0] out_tdata, // lat, lon, vel_lat, vel_lon, var_lat, var_lon, pad
  input  logic         cfg_wr_en,
  input  logic         cfg_index,
  input  logic [32:0]  cfg_wdata
);
  import kpv_pkg::*;
  `include "kalman_position_velocity_filter_defines.svh"

  localparam logic [3:0] StIdle = 4'd0, StMul = 4'd1, StMulW = 4'd2, StDiv = 4'd3,
                         StDivW = 4'd4, StOut = 4'd5;

  logic [32:0] q_r, r_r;
  logic [63:0] pos_r [2], vel_r [2], pp_r [2], pv_r [2];
  logic [63:0] gps_r [2], acc_r [2], dt_r, dt2_r, adt_r, k_r, t_r;
  logic [1:0]  cmd_r;
  logic [3:0]  st_r;
  logic [3:0]  op_r;
  logic        ax_r;
  logic        ov_r;
  kpv_mul_req_t mreq;
  kpv_mul_rsp_t mrsp;
  kpv_div_req_t dreq;
  kpv_div_rsp_t drsp;
  logic [63:0] y, s;

  kpv_mul u_mul (.clk(clk), .rst_n(rst_n), .req(mreq), .rsp(mrsp));
  kpv_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  assign in_tready  = (st_r == StIdle) && !ov_r;
  assign out_tvalid = ov_r;

  assign y = ssub(gps_r[ax_r], pos_r[ax_r]);
  assign s = vadd(pp_r[ax_r], {31'd0, r_r});

  // multiply sequence: predict op 0 forms dt2, then ops 1..4 per axis; update ops 0..1
  always_comb begin
    mreq = '0;
    mreq.start = (st_r == StMul);
    mreq.sgn = 1'b1;
    if (cmd_r == CmdPredict) begin
      unique case (op_r)
        4'd0: begin mreq.sgn = 1'b0; mreq.a = dt_r; mreq.b = dt_r; end
        4'd1: begin mreq.a = acc_r[ax_r]; mreq.b = dt_r; end
        4'd2: begin mreq.a = adt_r; mreq.b = dt_r; end
        4'd3: begin mreq.a = vel_r[ax_r]; mreq.b = dt_r; end
        default: begin mreq.sgn = 1'b0; mreq.a = dt2_r; mreq.b = pv_r[ax_r]; end
      endcase
    end else begin
      if (op_r == 4'd0) begin mreq.a = k_r; mreq.b = y; end
      else begin mreq.sgn = 1'b0; mreq.a = OneQ - k_r; mreq.b = pp_r[ax_r]; end
    end
    dreq.start = (st_r == StDiv);
    dreq.p = pp_r[ax_r];
    dreq.s = s;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= StIdle; ov_r <= 1'b0;
      q_r <= ProcNoiseReset; r_r <= MeasNoiseReset;
      for (int i = 0; i < 2; i++) begin
        pos_r[i] <= '0; vel_r[i] <= '0; pp_r[i] <= OneQ; pv_r[i] <= OneQ;
      end
    end else begin
      if (cfg_wr_en) begin
        if (cfg_index == RegProcNoise) q_r <= cfg_wdata;
        else r_r <= cfg_wdata;
      end
      if (ov_r && out_tready) ov_r <= 1'b0;
      unique case (st_r)
        StIdle: if (in_tvalid && in_tready) begin
          cmd_r <= in_tuser;
          gps_r[0] <= in_tdata[63:0]; gps_r[1] <= in_tdata[127:64];
          acc_r[0] <= in_tdata[191:128]; acc_r[1] <= in_tdata[255:192];
          dt_r <= {1'b0, in_tdata[318:256]};
          op_r <= '0; ax_r <= 1'b0;
          unique case (in_tuser)
            CmdInit: begin
              pos_r[0] <= in_tdata[63:0]; pos_r[1] <= in_tdata[127:64];
              for (int i = 0; i < 2; i++) begin
                vel_r[i] <= '0; pp_r[i] <= OneQ; pv_r[i] <= OneQ;
              end
              st_r <= StOut;
            end
            CmdPredict: st_r <= StMul;
            CmdUpdate: st_r <= StDiv;
            default: st_r <= StOut;
          endcase
        end
        StMul: st_r <= StMulW;
        StMulW: if (mrsp.done) begin
          if (cmd_r == CmdPredict) begin
            unique case (op_r)
              4'd0: begin dt2_r <= mrsp.res; op_r <= 4'd1; st_r <= StMul; end
              4'd1: begin adt_r <= mrsp.res; op_r <= 4'd2; st_r <= StMul; end
              4'd2: begin
                t_r <= {mrsp.res[63], mrsp.res[63:1]} +
                       {63'd0, mrsp.res[63] & mrsp.res[0]};
                op_r <= 4'd3;
                st_r <= StMul;
              end
              4'd3: begin
                pos_r[ax_r] <= sadd(sadd(pos_r[ax_r], mrsp.res), t_r);
                vel_r[ax_r] <= sadd(vel_r[ax_r], adt_r);
                op_r <= 4'd4;
                st_r <= StMul;
              end
              default: begin
                pp_r[ax_r] <= vadd(vadd(pp_r[ax_r], mrsp.res), {31'd0, q_r});
                pv_r[ax_r] <= vadd(pv_r[ax_r], {31'd0, q_r});
                op_r <= 4'd1;
                ax_r <= 1'b1;
                st_r <= ax_r ? StOut : StMul;
              end
            endcase
          end else begin
            if (op_r == 4'd0) begin
              pos_r[ax_r] <= sadd(pos_r[ax_r], mrsp.res);
              op_r <= 4'd1;
              st_r <= StMul;
            end else begin
              pp_r[ax_r] <= mrsp.res;
              op_r <= 4'd0;
              ax_r <= 1'b1;
              st_r <= ax_r ? StOut : StDiv;
            end
          end
        end
        StDiv: st_r <= StDivW;
        StDivW: if (drsp.done) begin
          k_r <= drsp.q;
          st_r <= StMul;
        end
        StOut: begin
          ov_r <= 1'b1;
          st_r <= StIdle;
        end
        default: st_r <= StIdle;
      endcase
    end
  end

  assign out_tdata = {2'd0, pp_r[1][62:0], pp_r[0][62:0], vel_r[1], vel_r[0],
                      pos_r[1], pos_r[0]};

  `KPV_ASSERT_IMP(a_ready_idle, clk, rst_n, in_tready, st_r == StIdle, "ready outside idle")
  `KPV_ASSERT_NXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid, "result dropped")
  `KPV_ASSERT_IMP(a_busy_no_out, clk, rst_n, st_r != StIdle, !out_tvalid, "result while busy")
endmodule

>>> rtl/kpv_mul.sv
// ----------------------------------------------------------------------------
// kpv_mul
// shared q32.32 multiplier, four 32x32 partial products accumulated in sequence
// ----------------------------------------------------------------------------
module kpv_mul (
  input  logic                  clk,
  input  logic                  rst_n,
  input  kpv_pkg::kpv_mul_req_t req,
  output kpv_pkg::kpv_mul_rsp_t rsp
);
  import kpv_pkg::*;

  logic [63:0]  ma_r, mb_r, ma_nxt, mb_nxt;
  logic         neg_r, neg_nxt, sgn_r, sgn_nxt;
  logic [127:0] acc_r, acc_nxt;
  logic [2:0]   step_r, step_nxt;
  logic         busy_r, busy_nxt;
  logic [63:0]  prod;
  logic [31:0]  pa, pb;
  logic [63:0]  m;
  logic         ovf;
  logic [63:0]  res;

  always_comb begin
    unique case (step_r[1:0])
      2'd0: begin pa = ma_r[31:0];  pb = mb_r[31:0];  end
      2'd1: begin pa = ma_r[31:0];  pb = mb_r[63:32]; end
      2'd2: begin pa = ma_r[63:32]; pb = mb_r[31:0];  end
      default: begin pa = ma_r[63:32]; pb = mb_r[63:32]; end
    endcase
    prod = {32'd0, pa} * {32'd0, pb};
  end

  always_comb begin
    m   = acc_r[95:32];
    ovf = |acc_r[127:96];
    if (!sgn_r) res = (ovf || m[63]) ? VMax : m;
    else if (!neg_r) res = (ovf || m[63]) ? VMax : m;
    else if (ovf || m[63]) res = SMin;
    else res = 64'd0 - m;
  end

  always_comb begin
    ma_nxt = ma_r; mb_nxt = mb_r; neg_nxt = neg_r; sgn_nxt = sgn_r;
    acc_nxt = acc_r; step_nxt = step_r; busy_nxt = busy_r;
    if (req.start) begin
      sgn_nxt  = req.sgn;
      ma_nxt   = (req.sgn && req.a[63]) ? 64'd0 - req.a : req.a;
      mb_nxt   = (req.sgn && req.b[63]) ? 64'd0 - req.b : req.b;
      neg_nxt  = req.sgn && (req.a[63] != req.b[63]);
      acc_nxt  = '0;
      step_nxt = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      unique case (step_r[1:0])
        2'd0: acc_nxt = acc_r + {64'd0, prod};
        2'd1, 2'd2: acc_nxt = acc_r + {32'd0, prod, 32'd0};
        default: acc_nxt = acc_r + {prod, 64'd0};
      endcase
      step_nxt = step_r + 3'd1;
      if (step_r == 3'd3) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      step_r <= step_nxt;
    end
    ma_r <= ma_nxt; mb_r <= mb_nxt; neg_r <= neg_nxt; sgn_r <= sgn_nxt;
    acc_r <= acc_nxt;
  end

  assign rsp.done = !busy_r && step_r == 3'd4;
  assign rsp.res  = res;
endmodule

>>> rtl/kpv_div.sv
// ----------------------------------------------------------------------------
// kpv_div
// restoring divider for the update gain, one quotient bit per cycle
// ----------------------------------------------------------------------------
module kpv_div (
  input  logic                  clk,
  input  logic                  rst_n,
  input  kpv_pkg::kpv_div_req_t req,
  output kpv_pkg::kpv_div_rsp_t rsp
);
  import kpv_pkg::*;

  // dividend p * 2^32 is 96 bits; quotient fits 64 bits since p <= s
  logic [95:0] num_r, num_nxt;
  logic [64:0] rem_r, rem_nxt;
  logic [63:0] s_r, s_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt, done_r, done_nxt;
  logic [64:0] sh;

  always_comb begin
    num_nxt = num_r; rem_nxt = rem_r; s_nxt = s_r;
    cnt_nxt = cnt_r; busy_nxt = busy_r; done_nxt = 1'b0;
    sh = {rem_r[63:0], num_r[95]};
    if (req.start) begin
      num_nxt  = {req.p, 32'd0};
      rem_nxt  = '0;
      s_nxt    = req.s;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      num_nxt = {num_r[94:0], 1'b0};
      if (sh >= {1'b0, s_r}) begin
        rem_nxt    = sh - {1'b0, s_r};
        num_nxt[0] = 1'b1;
      end else begin
        rem_nxt = sh;
      end
      cnt_nxt = cnt_r + 7'd1;
      if (cnt_r == 7'd95) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    num_r <= num_nxt; rem_r <= rem_nxt; s_r <= s_nxt; cnt_r <= cnt_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.q    = (s_r == 64'd0) ? 64'd0 : num_r[63:0];
endmodule

>>> dv/kalman_position_velocity_filter_tb.sv
// ----------------------------------------------------------------------------
// kalman_position_velocity_filter_tb
// Streams init, predict and update requests through the filter and checks
// every result against a cycle-free Q32.32 model of the filter state. The
// input side sends in random bursts and the result side stalls on its own
// pattern. Between phases the noise registers are rewritten while the filter
// is idle, covering zero, one, the 33-bit maximum and random values.
// ----------------------------------------------------------------------------
module kalman_position_velocity_filter_tb;
  import kpv_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [1:0]  cmd;
    logic [63:0] plat;
    logic [63:0] plon;
    logic [63:0] alat;
    logic [63:0] alon;
    logic [62:0] dt;
  } filter_req_t;

  typedef struct {
    logic [63:0] lat;
    logic [63:0] lon;
    logic [63:0] vlat;
    logic [63:0] vlon;
    logic [62:0] plat_var;
    logic [62:0] plon_var;
  } filter_est_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [319:0] in_tdata;  // pos_lat, pos_lon, acc_lat, acc_lon, time_step, pad
  logic [1:0]   in_tuser;  // command
  logic         out_tvalid;
  logic         out_tready;
  logic [383:0] out_tdata; // lat, lon, vel_lat, vel_lon, var_lat, var_lon, pad
  logic         cfg_wr_en;
  logic         cfg_index;
  logic [32:0]  cfg_wdata;

  filter_req_t pending_reqs[$];
  filter_est_t expected_ests[$];

  logic [63:0] proc_noise, meas_noise;
  logic [63:0] st_lat, st_lon, st_vlat, st_vlon;
  logic [63:0] pv_lat, pv_lon, vv_lat, vv_lon;

  int unsigned err_count = 0;
  int unsigned idle_cycles = 0;
  int unsigned cycle_cnt = 0;
  int unsigned gap_left = 0;
  int unsigned burst_left = 0;
  int unsigned seq_left = 0;
  logic        in_taken;

  kalman_position_velocity_filter DUT (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // q32.32 arithmetic
  function automatic logic [64:0] umul_q(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return {|p[127:96], p[95:32]};
  endfunction

  function automatic logic [63:0] var_mul(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] r;
    r = umul_q(a, b);
    return (r[64] || r[63]) ? VMax : r[63:0];
  endfunction

  function automatic logic [63:0] var_add(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] r;
    r = {1'b0, a} + {1'b0, b};
    return (r[64] || r[63]) ? VMax : r[63:0];
  endfunction

  function automatic logic [63:0] sat_mul(input logic [63:0] a, input logic [63:0] b);
    logic        neg;
    logic [63:0] ma, mb;
    logic [64:0] m;
    neg = a[63] ^ b[63];
    ma = a[63] ? -a : a;
    mb = b[63] ? -b : b;
    m = umul_q(ma, mb);
    if (!neg) return (m[64] || m[63]) ? VMax : m[63:0];
    if (m[64] || m[63]) return SMin;
    return -m[63:0];
  endfunction

  function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] r;
    r = a + b;
    if (a[63] == b[63] && r[63] != a[63]) return a[63] ? SMin : VMax;
    return r;
  endfunction

  function automatic logic [63:0] sat_sub(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] r;
    r = a - b;
    if (a[63] != b[63] && r[63] != a[63]) return a[63] ? SMin : VMax;
    return r;
  endfunction

  function automatic logic [63:0] kalman_gain(input logic [63:0] p, input logic [63:0] s);
    logic [127:0] q;
    if (s == 64'd0) return 64'd0;
    q = {32'd0, p, 32'd0} / {64'd0, s};
    return q[63:0];
  endfunction

  task automatic predict_axis(inout logic [63:0] pos, inout logic [63:0] vel,
                              inout logic [63:0] pp, inout logic [63:0] pv,
                              input logic [63:0] acc, input logic [63:0] dt,
                              input logic [63:0] dt2);
    logic [63:0] adt;
    longint      half;
    adt = sat_mul(acc, dt);
    half = longint'(sat_mul(adt, dt)) / 2;
    pos = sat_add(sat_add(pos, sat_mul(vel, dt)), half);
    vel = sat_add(vel, adt);
    pp = var_add(var_add(pp, var_mul(dt2, pv)), proc_noise);
    pv = var_add(pv, proc_noise);
  endtask

  task automatic update_axis(inout logic [63:0] pos, inout logic [63:0] pp,
                             input logic [63:0] meas);
    logic [63:0] y, s, k;
    y = sat_sub(meas, pos);
    s = var_add(pp, meas_noise);
    k = kalman_gain(pp, s);
    pos = sat_add(pos, sat_mul(k, y));
    pp = var_mul(OneQ - k, pp);
  endtask

  task automatic load_state(input logic [63:0] lat, input logic [63:0] lon);
    st_lat = lat;
    st_lon = lon;
    st_vlat = 64'd0;
    st_vlon = 64'd0;
    pv_lat = OneQ;
    pv_lon = OneQ;
    vv_lat = OneQ;
    vv_lon = OneQ;
  endtask

  task automatic filter_step(input filter_req_t r);
    filter_est_t e;
    logic [63:0] dt, dt2;
    dt = {1'b0, r.dt};
    case (r.cmd)
      CmdInit: begin
        load_state(r.plat, r.plon);
      end
      CmdPredict: begin
        dt2 = var_mul(dt, dt);
        predict_axis(st_lat, st_vlat, pv_lat, vv_lat, r.alat, dt, dt2);
        predict_axis(st_lon, st_vlon, pv_lon, vv_lon, r.alon, dt, dt2);
      end
      CmdUpdate: begin
        update_axis(st_lat, pv_lat, r.plat);
        update_axis(st_lon, pv_lon, r.plon);
      end
      default: ;
    endcase
    e.lat = st_lat;
    e.lon = st_lon;
    e.vlat = st_vlat;
    e.vlon = st_vlon;
    e.plat_var = pv_lat[62:0];
    e.plon_var = pv_lon[62:0];
    expected_ests.push_back(e);
  endtask

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] exp);
    $display("%0t: %s mismatch: got %h expected %h", $realtime, what, got, exp);
    err_count++;
  endtask

  // reset, driver and monitor
  initial begin
    rst_n = 1'b0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;
  end

  always @(negedge clk) begin
    filter_req_t r;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata <= '0;
      in_tuser <= '0;
    end else if (!(in_tvalid && !in_taken)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_tvalid <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        r = pending_reqs.pop_front();
        in_tdata <= {1'b0, r.dt, r.alon, r.alat, r.plon, r.plat};
        in_tuser <= r.cmd;
        in_tvalid <= 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 12);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // ready pattern: always ready, coin flip, or long stalls, taken in turn
  always @(negedge clk) begin
    cycle_cnt++;
    case ((cycle_cnt >> 8) % 3)
      0: out_tready <= 1'b1;
      1: out_tready <= 1'($urandom_range(0, 1));
      default: out_tready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  always @(posedge clk) begin
    filter_req_t r;
    filter_est_t e;
    in_taken <= rst_n && in_tvalid && in_tready;
    if (rst_n && in_tvalid && in_tready) begin
      r.plat = in_tdata[63:0];
      r.plon = in_tdata[127:64];
      r.alat = in_tdata[191:128];
      r.alon = in_tdata[255:192];
      r.dt = in_tdata[318:256];
      r.cmd = in_tuser;
      filter_step(r);
    end
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_ests.size() == 0) begin
        $display("%0t: result with no request outstanding", $realtime);
        err_count++;
      end else begin
        e = expected_ests.pop_front();
        if (out_tdata[63:0] !== e.lat) report("est_lat", out_tdata[63:0], e.lat);
        if (out_tdata[127:64] !== e.lon) report("est_lon", out_tdata[127:64], e.lon);
        if (out_tdata[191:128] !== e.vlat) report("est_vel_lat", out_tdata[191:128], e.vlat);
        if (out_tdata[255:192] !== e.vlon) report("est_vel_lon", out_tdata[255:192], e.vlon);
        if (out_tdata[318:256] !== e.plat_var)
          report("out_var_lat", {1'b0, out_tdata[318:256]}, {1'b0, e.plat_var});
        if (out_tdata[381:319] !== e.plon_var)
          report("out_var_lon", {1'b0, out_tdata[381:319]}, {1'b0, e.plon_var});
      end
    end
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("kalman_position_velocity_filter test failed");
      $finish;
    end
  end

  // stimulus
  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [63:0] rand_q(input int span);
    int ip;
    ip = int'($urandom_range(0, 2 * span)) - span;
    return {ip, $urandom()};
  endfunction

  function automatic logic [62:0] rand_dt();
    return {31'($urandom_range(0, 2)), $urandom()};
  endfunction

  task automatic push_req(input logic [1:0] cmd, input logic [63:0] plat,
                          input logic [63:0] plon, input logic [63:0] alat,
                          input logic [63:0] alon, input logic [62:0] dt);
    filter_req_t r;
    r.cmd = cmd;
    r.plat = plat;
    r.plon = plon;
    r.alat = alat;
    r.alon = alon;
    r.dt = dt;
    pending_reqs.push_back(r);
  endtask

  task automatic push_random();
    if ($urandom_range(0, 99) < 85) begin
      if (seq_left == 0) begin
        seq_left = $urandom_range(5, 30);
        push_req(CmdInit, rand_q(1000000), rand_q(1000000), rand64(), rand64(), rand_dt());
      end else begin
        seq_left--;
        if ($urandom_range(0, 9) < 6)
          push_req(CmdPredict, rand64(), rand64(), rand_q(16), rand_q(16), rand_dt());
        else
          push_req(CmdUpdate, sat_add(st_lat, rand_q(50)), rand_q(1000000),
                   rand64(), rand64(), rand_dt());
      end
    end else begin
      push_req(2'($urandom_range(0, 3)), rand64(), rand64(), rand64(), rand64(),
               63'(rand64()));
    end
  endtask

  task automatic wait_idle();
    while (pending_reqs.size() > 0 || in_tvalid || expected_ests.size() > 0)
      @(negedge clk);
    repeat (300) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [32:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == RegProcNoise) proc_noise = {31'd0, val};
    else meas_noise = {31'd0, val};
  endtask

  task automatic push_directed();
    push_req(CmdInit, SMin, VMax, 64'd0, 64'd0, 63'd0);
    push_req(CmdPredict, 64'd0, 64'd0, VMax, SMin, {63{1'b1}});
    push_req(CmdPredict, 64'd0, 64'd0, SMin, VMax, {63{1'b1}});
    push_req(CmdUpdate, VMax, SMin, 64'd0, 64'd0, 63'd0);
    push_req(CmdInit, 64'd0, 64'd0, 64'd0, 64'd0, 63'd0);
    push_req(CmdPredict, 64'd0, 64'd0, OneQ, -OneQ, 63'd0);
    push_req(CmdPredict, 64'd0, 64'd0, OneQ, -OneQ, 63'h0_8000_0000);
    push_req(CmdPredict, 64'd0, 64'd0, -OneQ, OneQ, 63'h1_0000_0000);
    push_req(CmdUpdate, OneQ, -OneQ, 64'd0, 64'd0, 63'd0);
    push_req(CmdUpdate, OneQ, -OneQ, 64'd0, 64'd0, 63'd0);
    push_req(CmdUpdate, 64'd0, 64'd0, 64'd0, 64'd0, 63'd0);
    push_req(2'd3, VMax, SMin, VMax, SMin, {63{1'b1}});
    push_req(CmdPredict, VMax, VMax, VMax, VMax, 63'h7_0000_0000);
    push_req(CmdInit, VMax, SMin, 64'd0, 64'd0, 63'd0);
    push_req(CmdUpdate, SMin, VMax, 64'd0, 64'd0, 63'd0);
    push_req(CmdPredict, 64'd0, 64'd0, -OneQ, -OneQ, 63'h7FFF_FFFF_0000_0000);
    seq_left = 0;
  endtask

  initial begin
    logic [32:0] q_vals[8];
    logic [32:0] r_vals[8];
    cfg_wr_en = 1'b0;
    cfg_index = RegProcNoise;
    cfg_wdata = '0;
    proc_noise = {31'd0, ProcNoiseReset};
    meas_noise = {31'd0, MeasNoiseReset};
    load_state(64'd0, 64'd0);
    q_vals = '{ProcNoiseReset, 33'd0, 33'h1_0000_0000, 33'h1_FFFF_FFFF, 33'd0,
               33'($urandom()), {1'b1, $urandom()}, ProcNoiseReset};
    r_vals = '{MeasNoiseReset, 33'd0, 33'h1_0000_0000, 33'd0, 33'h1_FFFF_FFFF,
               33'($urandom()), {1'b1, $urandom()}, MeasNoiseReset};
    @(posedge rst_n);
    for (int ph = 0; ph < 8; ph++) begin
      if (ph > 0) begin
        write_reg(RegProcNoise, q_vals[ph]);
        write_reg(RegMeasNoise, r_vals[ph]);
      end
      if (ph < 2) push_directed();
      for (int i = 0; i < 160; i++) begin
        // generated as the filter drains so updates can aim near the estimate
        while (pending_reqs.size() > 4) @(negedge clk);
        push_random();
      end
      wait_idle();
    end
    if (err_count == 0) begin
      $display("kalman_position_velocity_filter test passed");
    end else begin
      $display("kalman_position_velocity_filter test failed");
    end
    $finish;
  end

endmodule
